FILE: src/btms_pkg.sv
package btms_pkg;

   // phase codes as seen on the result channel
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_VALIDATE = 3'd1,
      PH_RED      = 3'd2,
      PH_COUNT    = 3'd3,
      PH_MOTOR    = 3'd4
   } phase_type;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKET_VALID        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_HOLD_TICKS      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS        = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS      = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_TICKS_DEFAULT = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_TICKS_ONE     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_TICKS_TWO     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_TICKS_THREE   = 4'd7;

   // register reset values
   localparam logic        RST_TICKET_VALID        = 1'b1;
   localparam logic [15:0] RST_RED_HOLD_TICKS      = 16'd1000;
   localparam logic [15:0] RST_WINDOW_TICKS        = 16'd300;
   localparam logic [15:0] RST_DEBOUNCE_TICKS      = 16'd2;
   localparam logic [15:0] RST_MOTOR_TICKS_DEFAULT = 16'd500;
   localparam logic [15:0] RST_MOTOR_TICKS_ONE     = 16'd1000;
   localparam logic [15:0] RST_MOTOR_TICKS_TWO     = 16'd2000;
   localparam logic [15:0] RST_MOTOR_TICKS_THREE   = 16'd4000;

   typedef struct packed {
      logic        ticket_valid;
      logic [15:0] red_hold_ticks;
      logic [15:0] window_ticks;
      logic [15:0] debounce_ticks;
      logic [15:0] motor_ticks_default;
      logic [15:0] motor_ticks_one;
      logic [15:0] motor_ticks_two;
      logic [15:0] motor_ticks_three;
   } cfg_type;

   typedef struct packed {
      logic       red_lamp;
      logic       motor_on;
      logic [2:0] phase;
      logic [7:0] presses;
   } rsp_type;

endpackage

FILE: src/btms_core.sv
module btms_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              tick,
   input  logic              car_event,
   input  logic              button_pin,
   input  btms_pkg::cfg_type cfg,
   output btms_pkg::rsp_type result
);

   btms_pkg::phase_type phase_ff, phase_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] mark_ff, mark_in;
   logic [31:0] last_press_ff, last_press_in;
   logic [7:0]  count_ff, count_in;
   logic        was_pressed_ff, was_pressed_in;
   logic [15:0] run_ff, run_in;
   logic        lamp_ff, lamp_in;
   logic        motor_ff, motor_in;

   logic        pressed;
   logic [31:0] elapsed;
   logic [31:0] since_press;
   logic [31:0] now_base;
   logic [15:0] run_pick;

   assign pressed     = ~button_pin;
   assign elapsed     = now_ff - mark_ff;
   assign since_press = now_ff - last_press_ff;

   always_comb begin
      case (count_ff)
         8'd1:    run_pick = cfg.motor_ticks_one;
         8'd2:    run_pick = cfg.motor_ticks_two;
         8'd3:    run_pick = cfg.motor_ticks_three;
         default: run_pick = cfg.motor_ticks_default;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      now_base       = now_ff;
      mark_in        = mark_ff;
      last_press_in  = last_press_ff;
      count_in       = count_ff;
      was_pressed_in = was_pressed_ff;
      run_in         = run_ff;
      lamp_in        = lamp_ff;
      motor_in       = motor_ff;
      case (phase_ff)
         btms_pkg::PH_VALIDATE: begin
            mark_in = now_ff;
            if (!cfg.ticket_valid) begin
               lamp_in  = 1'b1;
               phase_in = btms_pkg::PH_RED;
            end else begin
               phase_in = btms_pkg::PH_COUNT;
            end
         end
         btms_pkg::PH_RED: begin
            if (elapsed >= {16'd0, cfg.red_hold_ticks}) begin
               lamp_in  = 1'b0;
               phase_in = btms_pkg::PH_IDLE;
            end
         end
         btms_pkg::PH_COUNT: begin
            if (elapsed <= {16'd0, cfg.window_ticks}) begin
               if (pressed && !was_pressed_ff &&
                   since_press >= {16'd0, cfg.debounce_ticks}) begin
                  last_press_in = now_ff;
                  count_in      = count_ff + 8'd1;
               end
               was_pressed_in = pressed;
            end else begin
               run_in   = run_pick;
               motor_in = 1'b1;
               mark_in  = now_ff;
               phase_in = btms_pkg::PH_MOTOR;
            end
         end
         btms_pkg::PH_MOTOR: begin
            if (elapsed >= {16'd0, run_ff}) begin
               motor_in = 1'b0;
               phase_in = btms_pkg::PH_IDLE;
            end
         end
         default: begin
            // idle: clear every timer and counter
            phase_in       = btms_pkg::PH_IDLE;
            now_base       = 32'd0;
            mark_in        = 32'd0;
            last_press_in  = 32'd0;
            count_in       = 8'd0;
            was_pressed_in = 1'b0;
            run_in         = 16'd0;
            lamp_in        = 1'b0;
            motor_in       = 1'b0;
         end
      endcase
      now_in = now_base + {31'd0, tick};
      if (car_event && phase_in == btms_pkg::PH_IDLE) begin
         phase_in = btms_pkg::PH_VALIDATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= btms_pkg::PH_IDLE;
         now_ff         <= 32'd0;
         mark_ff        <= 32'd0;
         last_press_ff  <= 32'd0;
         count_ff       <= 8'd0;
         was_pressed_ff <= 1'b0;
         run_ff         <= 16'd0;
         lamp_ff        <= 1'b0;
         motor_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         now_ff         <= now_in;
         mark_ff        <= mark_in;
         last_press_ff  <= last_press_in;
         count_ff       <= count_in;
         was_pressed_ff <= was_pressed_in;
         run_ff         <= run_in;
         lamp_ff        <= lamp_in;
         motor_ff       <= motor_in;
      end
   end

   assign result.red_lamp = lamp_in;
   assign result.motor_on = motor_in;
   assign result.phase    = phase_in;
   assign result.presses  = count_in;

endmodule

FILE: src/btms_skid.sv
module btms_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  btms_pkg::rsp_type in_data,
   output logic              in_stall,
   output logic              out_valid,
   output btms_pkg::rsp_type out_data,
   input  logic              out_stall
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   btms_pkg::rsp_type out_data_ff, out_data_in;
   btms_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_take;
   logic              in_take;

   assign out_take = out_valid_ff & ~out_stall;
   assign in_take  = in_valid & ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_take) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: src/barrier_ticket_motor_sequencer.sv
// channel   | direction | handshake          | payload
// req_      | in        | req_valid/req_stall | req_tick, req_car_event, req_button_pin
// rsp_      | out       | rsp_valid/rsp_stall | rsp_red_lamp, rsp_motor_on, rsp_phase,
//           |           |                    | rsp_presses
// csr_      | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// one request per clock while req_stall is low; its response is registered on acceptance
// the phase update is one pass of compares and 32-bit subtracts between state registers
// a two-entry output buffer still takes a request while rsp_stall holds the output
// req_stall rises only when both entries hold responses
// synchronous reset returns the phase to idle and the registers to their defaults
module barrier_ticket_motor_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_tick,
   input  logic                                req_car_event,
   input  logic                                req_button_pin,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_red_lamp,
   output logic                                rsp_motor_on,
   output logic [2:0]                          rsp_phase,
   output logic [7:0]                          rsp_presses,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [btms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [btms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   btms_pkg::cfg_type cfg_ff, cfg_in;
   btms_pkg::rsp_type core_result;
   btms_pkg::rsp_type rsp_data;
   logic              req_take;

   // config writes are always taken
   assign csr_ready = 1'b1;

   // register file, out of range indexes fall through untouched
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            btms_pkg::CSR_TICKET_VALID:        cfg_in.ticket_valid        = csr_wdata[0];
            btms_pkg::CSR_RED_HOLD_TICKS:      cfg_in.red_hold_ticks      = csr_wdata;
            btms_pkg::CSR_WINDOW_TICKS:        cfg_in.window_ticks        = csr_wdata;
            btms_pkg::CSR_DEBOUNCE_TICKS:      cfg_in.debounce_ticks      = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_DEFAULT: cfg_in.motor_ticks_default = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_ONE:     cfg_in.motor_ticks_one     = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_TWO:     cfg_in.motor_ticks_two     = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_THREE:   cfg_in.motor_ticks_three   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticket_valid        <= btms_pkg::RST_TICKET_VALID;
         cfg_ff.red_hold_ticks      <= btms_pkg::RST_RED_HOLD_TICKS;
         cfg_ff.window_ticks        <= btms_pkg::RST_WINDOW_TICKS;
         cfg_ff.debounce_ticks      <= btms_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.motor_ticks_default <= btms_pkg::RST_MOTOR_TICKS_DEFAULT;
         cfg_ff.motor_ticks_one     <= btms_pkg::RST_MOTOR_TICKS_ONE;
         cfg_ff.motor_ticks_two     <= btms_pkg::RST_MOTOR_TICKS_TWO;
         cfg_ff.motor_ticks_three   <= btms_pkg::RST_MOTOR_TICKS_THREE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a request is taken whenever the output buffer has a free entry
   assign req_take = req_valid & ~req_stall;

   // phase logic and its state registers
   btms_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_take),
      .tick       (req_tick),
      .car_event  (req_car_event),
      .button_pin (req_button_pin),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   // response register plus one skid entry
   btms_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (core_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_red_lamp = rsp_data.red_lamp;
   assign rsp_motor_on = rsp_data.motor_on;
   assign rsp_phase    = rsp_data.phase;
   assign rsp_presses  = rsp_data.presses;

`ifndef SYNTHESIS
   // lamp and motor are never driven together
   a_lamp_motor_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_red_lamp && rsp_motor_on))
      else $error("red lamp and motor both on");

   // an idle response carries both drives low
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == btms_pkg::PH_IDLE) |-> (!rsp_red_lamp && !rsp_motor_on))
      else $error("drive active in idle");

   // the buffer only stalls requests when a response is waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stall with empty output");

   // a taken request always leaves a response valid next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request accepted but no response");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

   // watchdog, far above what the whole run needs even with every idle gap and stall
   localparam int unsigned CYCLE_LIMIT  = 100_000;
   localparam int unsigned RANDOM_ITEMS = 250;
   localparam int unsigned IDX_W        = btms_pkg::CSR_INDEX_W;
   localparam int unsigned DATA_W       = btms_pkg::CSR_DATA_W;
   // register indexes past the last register, writes there must be ignored
   localparam logic [IDX_W-1:0] CSR_UNUSED_LO = 4'd8;
   localparam logic [IDX_W-1:0] CSR_UNUSED_HI = 4'd15;
   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_tick       = 1'b0;
   logic       req_car_event  = 1'b0;
   logic       req_button_pin = 1'b1;

   // response channel
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_red_lamp;
   logic       rsp_motor_on;
   logic [2:0] rsp_phase;
   logic [7:0] rsp_presses;

   // register write channel
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   // no idling on either side while set
   bit quiet_mode = 1'b0;
   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;

   // shadow of the registers, starts at the reset values
   btms_pkg::cfg_type gate_cfg = '{ticket_valid:        btms_pkg::RST_TICKET_VALID,
                                   red_hold_ticks:      btms_pkg::RST_RED_HOLD_TICKS,
                                   window_ticks:        btms_pkg::RST_WINDOW_TICKS,
                                   debounce_ticks:      btms_pkg::RST_DEBOUNCE_TICKS,
                                   motor_ticks_default: btms_pkg::RST_MOTOR_TICKS_DEFAULT,
                                   motor_ticks_one:     btms_pkg::RST_MOTOR_TICKS_ONE,
                                   motor_ticks_two:     btms_pkg::RST_MOTOR_TICKS_TWO,
                                   motor_ticks_three:   btms_pkg::RST_MOTOR_TICKS_THREE};

   // shadow of the sequencer state
   btms_pkg::phase_type gate_phase = btms_pkg::PH_IDLE;
   logic [31:0] tick_now        = '0;
   logic [31:0] tick_mark       = '0;
   logic [31:0] tick_last_press = '0;
   logic [7:0]  press_tally     = '0;
   logic        btn_held        = 1'b0;
   logic [15:0] run_len         = '0;
   logic        lamp_q          = 1'b0;
   logic        motor_q         = 1'b0;

   // one response per accepted request, oldest first
   btms_pkg::rsp_type expected_gate_q[$];

   barrier_ticket_motor_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tick       (req_tick),
      .req_car_event  (req_car_event),
      .req_button_pin (req_button_pin),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_lamp   (rsp_red_lamp),
      .rsp_motor_on   (rsp_motor_on),
      .rsp_phase      (rsp_phase),
      .rsp_presses    (rsp_presses),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("barrier_ticket_motor_sequencer regression: fail");
         $finish;
      end
   end

   // receiver back-pressure, about a third of the cycles unless quiet
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < 33);
      end
   end

   // one polled sample of the sequencer: phase pass, then tick, then car arrival
   function automatic btms_pkg::rsp_type predict_gate_outputs(input logic tick,
                                                              input logic car,
                                                              input logic pin);
      logic              pressed;
      logic [31:0]       elapsed;
      logic [31:0]       since_press;
      btms_pkg::rsp_type r;
      pressed     = ~pin;
      elapsed     = tick_now - tick_mark;
      since_press = tick_now - tick_last_press;
      case (gate_phase)
         btms_pkg::PH_VALIDATE: begin
            tick_mark = tick_now;
            if (!gate_cfg.ticket_valid) begin
               lamp_q     = 1'b1;
               gate_phase = btms_pkg::PH_RED;
            end else begin
               gate_phase = btms_pkg::PH_COUNT;
            end
         end
         btms_pkg::PH_RED: begin
            if (elapsed >= {16'd0, gate_cfg.red_hold_ticks}) begin
               lamp_q     = 1'b0;
               gate_phase = btms_pkg::PH_IDLE;
            end
         end
         btms_pkg::PH_COUNT: begin
            if (elapsed <= {16'd0, gate_cfg.window_ticks}) begin
               // count a pressed edge only once the debounce time has passed
               if (pressed && !btn_held && since_press >= {16'd0, gate_cfg.debounce_ticks}) begin
                  tick_last_press = tick_now;
                  press_tally     = press_tally + 8'd1;
               end
               btn_held = pressed;
            end else begin
               // zero presses and four or more share the default run time
               case (press_tally)
                  8'd1:    run_len = gate_cfg.motor_ticks_one;
                  8'd2:    run_len = gate_cfg.motor_ticks_two;
                  8'd3:    run_len = gate_cfg.motor_ticks_three;
                  default: run_len = gate_cfg.motor_ticks_default;
               endcase
               motor_q    = 1'b1;
               tick_mark  = tick_now;
               gate_phase = btms_pkg::PH_MOTOR;
            end
         end
         btms_pkg::PH_MOTOR: begin
            if (elapsed >= {16'd0, run_len}) begin
               motor_q    = 1'b0;
               gate_phase = btms_pkg::PH_IDLE;
            end
         end
         default: begin
            // idle clears every timer and counter on each sample
            gate_phase      = btms_pkg::PH_IDLE;
            tick_now        = '0;
            tick_mark       = '0;
            press_tally     = '0;
            run_len         = '0;
            btn_held        = 1'b0;
            tick_last_press = '0;
            lamp_q          = 1'b0;
            motor_q         = 1'b0;
         end
      endcase
      if (tick) begin
         tick_now = tick_now + 32'd1;
      end
      // a car outside idle is ignored
      if (car && gate_phase == btms_pkg::PH_IDLE) begin
         gate_phase = btms_pkg::PH_VALIDATE;
      end
      r.red_lamp = lamp_q;
      r.motor_on = motor_q;
      r.phase    = gate_phase;
      r.presses  = press_tally;
      return r;
   endfunction

   // accepted register writes and requests, sampled before the edge updates
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            btms_pkg::CSR_TICKET_VALID:        gate_cfg.ticket_valid        = csr_wdata[0];
            btms_pkg::CSR_RED_HOLD_TICKS:      gate_cfg.red_hold_ticks      = csr_wdata;
            btms_pkg::CSR_WINDOW_TICKS:        gate_cfg.window_ticks        = csr_wdata;
            btms_pkg::CSR_DEBOUNCE_TICKS:      gate_cfg.debounce_ticks      = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_DEFAULT: gate_cfg.motor_ticks_default = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_ONE:     gate_cfg.motor_ticks_one     = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_TWO:     gate_cfg.motor_ticks_two     = csr_wdata;
            btms_pkg::CSR_MOTOR_TICKS_THREE:   gate_cfg.motor_ticks_three   = csr_wdata;
            default: ;
         endcase
      end
      if (!reset && req_valid && !req_stall) begin
         expected_gate_q.push_back(
            predict_gate_outputs(req_tick, req_car_event, req_button_pin));
      end
   end

   // every accepted response against the oldest outstanding request
   always @(posedge clock) begin : check_responses
      btms_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_gate_q.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_gate_q.pop_front();
            if (rsp_red_lamp !== want.red_lamp) begin
               $error("red_lamp: expected %0d, got %0d", want.red_lamp, rsp_red_lamp);
               mismatch_count++;
            end
            if (rsp_motor_on !== want.motor_on) begin
               $error("motor_on: expected %0d, got %0d", want.motor_on, rsp_motor_on);
               mismatch_count++;
            end
            if (rsp_phase !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase, rsp_phase);
               mismatch_count++;
            end
            if (rsp_presses !== want.presses) begin
               $error("presses: expected %0d, got %0d", want.presses, rsp_presses);
               mismatch_count++;
            end
         end
      end
   end

   // one request, with a random gap ahead of it unless quiet
   task automatic send_request(input logic tick, input logic car, input logic pin);
      while (!quiet_mode && $urandom_range(99, 0) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_tick       <= tick;
      req_car_event  <= car;
      req_button_pin <= pin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait out every outstanding response
   task automatic await_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_gate_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller lowers it after the last write
   task automatic write_register(input logic [IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // all eight registers plus one write past the end, only with nothing in flight
   task automatic load_settings(input btms_pkg::cfg_type c);
      await_drain();
      write_register(btms_pkg::CSR_TICKET_VALID,        {15'd0, c.ticket_valid});
      write_register(btms_pkg::CSR_RED_HOLD_TICKS,      c.red_hold_ticks);
      write_register(btms_pkg::CSR_WINDOW_TICKS,        c.window_ticks);
      write_register(btms_pkg::CSR_DEBOUNCE_TICKS,      c.debounce_ticks);
      write_register(btms_pkg::CSR_MOTOR_TICKS_DEFAULT, c.motor_ticks_default);
      write_register(btms_pkg::CSR_MOTOR_TICKS_ONE,     c.motor_ticks_one);
      write_register(btms_pkg::CSR_MOTOR_TICKS_TWO,     c.motor_ticks_two);
      write_register(btms_pkg::CSR_MOTOR_TICKS_THREE,   c.motor_ticks_three);
      write_register(IDX_W'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)),
                     DATA_W'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // reset values in use: counted presses, then random ticks with the button released
   task automatic test_reset_defaults();
      send_request(1'b1, 1'b1, 1'b1);
      repeat (4) send_request(1'b1, 1'b0, 1'b1);
      repeat (2) send_request(1'b1, 1'b0, 1'b0);
      repeat (3) send_request(1'b1, 1'b0, 1'b1);
      repeat (2) send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b1, 1'b0, 1'b1);
      send_request(1'b1, 1'b0, 1'b0);
      repeat (20) send_request(1'($urandom_range(1, 0)), 1'b0, 1'b1);
   endtask

   // zero timers but short press run times, both ticket paths, every field combination
   task automatic test_corner_items();
      btms_pkg::cfg_type c;
      c = '{ticket_valid: 1'b0, default: 16'd0};
      load_settings(c);
      send_request(1'b0, 1'b1, 1'b0);
      for (int v = 0; v < 8; v++) send_request(v[0], v[1], v[2]);
      c = '{ticket_valid: 1'b1, red_hold_ticks: 16'd0, window_ticks: 16'd0,
            debounce_ticks: 16'd0, motor_ticks_default: 16'd0, motor_ticks_one: 16'd1,
            motor_ticks_two: 16'd2, motor_ticks_three: 16'd3};
      load_settings(c);
      send_request(1'b1, 1'b1, 1'b1);
      for (int v = 0; v < 8; v++) send_request(v[0], v[1], v[2]);
   endtask

   // largest timers: red hold and window at full size, debounce blocking every press
   task automatic test_long_timers();
      btms_pkg::cfg_type c;
      quiet_mode = 1'b1;
      c = '{ticket_valid: 1'b0, default: TICKS_MAX};
      load_settings(c);
      send_request(1'b0, 1'b1, 1'b1);
      repeat (40) send_request(1'b1, 1'b0, 1'($urandom_range(1, 0)));
      // end the hold, the car on the same request starts validation at once
      c.ticket_valid   = 1'b1;
      c.red_hold_ticks = 16'd0;
      load_settings(c);
      send_request(1'b1, 1'b1, 1'b1);
      repeat (40) send_request(1'b1, 1'b0, 1'($urandom_range(1, 0)));
      // close the window with short run times
      c.window_ticks        = 16'd0;
      c.motor_ticks_default = 16'd2;
      c.motor_ticks_one     = 16'd2;
      c.motor_ticks_two     = 16'd2;
      c.motor_ticks_three   = 16'd2;
      load_settings(c);
      repeat (6) send_request(1'b1, 1'b0, 1'b1);
      quiet_mode = 1'b0;
   endtask

   // more than 256 counted presses in one window, the tally wraps
   task automatic test_press_wrap();
      btms_pkg::cfg_type c;
      c = '{ticket_valid: 1'b1, red_hold_ticks: 16'd4, window_ticks: 16'd2,
            debounce_ticks: 16'd0, motor_ticks_default: 16'd3, motor_ticks_one: 16'd5,
            motor_ticks_two: 16'd7, motor_ticks_three: 16'd9};
      load_settings(c);
      send_request(1'b0, 1'b1, 1'b1);
      // no ticks while pressing, so the window stays open
      repeat (258) begin
         send_request(1'b0, 1'b0, 1'b1);
         send_request(1'b0, 1'b0, 1'b0);
      end
      repeat (14) send_request(1'b1, 1'b0, 1'b1);
   endtask

   // short timers, mostly car-started sequences with bouncing button, some noise
   task automatic test_random_traffic();
      btms_pkg::cfg_type c;
      int      sent;
      int      episode;
      int      len;
      logic    pin;
      sent    = 0;
      episode = 0;
      pin     = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         quiet_mode = (episode >= 2 && episode < 5);
         // new settings every fourth sequence, which also drains the pipe
         if (episode % 4 == 0) begin
            c.ticket_valid        = ($urandom_range(99, 0) < 70);
            c.red_hold_ticks      = 16'($urandom_range(8, 0));
            c.window_ticks        = 16'($urandom_range(12, 0));
            c.debounce_ticks      = 16'($urandom_range(3, 0));
            c.motor_ticks_default = 16'($urandom_range(10, 0));
            c.motor_ticks_one     = 16'($urandom_range(10, 0));
            c.motor_ticks_two     = 16'($urandom_range(10, 0));
            c.motor_ticks_three   = 16'($urandom_range(10, 0));
            load_settings(c);
         end
         len = $urandom_range(60, 10);
         if ($urandom_range(99, 0) < 80) begin
            send_request(1'($urandom_range(1, 0)), 1'b1, pin);
            repeat (len) begin
               if ($urandom_range(99, 0) < 35) pin = ~pin;
               send_request($urandom_range(99, 0) < 60, $urandom_range(99, 0) < 4, pin);
            end
            sent += len + 1;
         end else begin
            repeat (len) send_request(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                                      1'($urandom_range(1, 0)));
            sent += len;
         end
         episode++;
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_corner_items();
      test_long_timers();
      test_press_wrap();
      test_random_traffic();
      await_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("barrier_ticket_motor_sequencer regression: pass");
      end else begin
         $display("barrier_ticket_motor_sequencer regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
src/btms_pkg.sv
src/btms_core.sv
src/btms_skid.sv
src/barrier_ticket_motor_sequencer.sv
tb/sv/tb_top.sv
